// File: rtl/sps_pkg.sv
// ---------------------------------------------------------------------------
// Stepper phase sequencer package
// Item types, register indexes and the coil phase table.
// ---------------------------------------------------------------------------
package sps_pkg;

	// Input item: a start command with its move, or one coil period tick.
	typedef struct packed {
		logic        cmd;
		logic [15:0] move_degrees;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [7:0]  coil_pattern;
		logic [15:0] angle_now;
		logic        busy_res;
		logic        move_done;
	} out_item_t;

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION_CCW      = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_STEP_MODE     = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CYCLES_PER_SEGMENT = 2'd2;
	localparam int unsigned CFG_DATA_WIDTH = 8;

	localparam logic [7:0] CYCLES_PER_SEGMENT_RESET = 8'd22;
	localparam logic [7:0] COILS_OFF = 8'hFF;

	// Phase table positions.
	localparam logic [3:0] PHASE_FIRST = 4'd0;
	localparam logic [3:0] PHASE_LAST  = 4'd8;

	// Reciprocal of fifteen for a 16-bit dividend: floor(x * 0x8889 / 2^19).
	localparam logic [15:0] RECIP_15       = 16'h8889;
	localparam int unsigned RECIP_15_SHIFT = 19;

	// Coil energizing pattern for each phase; the last entry repeats the first.
	function automatic logic [7:0] phase_entry(input logic [3:0] idx);
		logic [7:0] e;
		case (idx)
			4'd0:    e = 8'h01;
			4'd1:    e = 8'h03;
			4'd2:    e = 8'h02;
			4'd3:    e = 8'h06;
			4'd4:    e = 8'h04;
			4'd5:    e = 8'h0C;
			4'd6:    e = 8'h08;
			4'd7:    e = 8'h09;
			4'd8:    e = 8'h01;
			default: e = 8'h01;
		endcase
		return e;
	endfunction

endpackage

// File: rtl/stepper_phase_sequencer.sv
// ---------------------------------------------------------------------------
// Stepper phase sequencer
// Half step / full step coil sequencer for a unipolar stepper motor.
// ---------------------------------------------------------------------------
//
//  Channel   Signals                         Carries
//  --------  ------------------------------  ---------------------------------
//  input     in_valid, in_ready, in_item     start command or coil tick
//  output    out_valid, out_ready, out_item  coil byte, angle, busy, done
//  config    cfg_we, cfg_index, cfg_data     direction, step mode, pass count
//
//  An accepted item updates the state at its edge and puts its result in the
//  output register, or the skid entry while the output entry is held. An item
//  can be taken every cycle while the skid entry is empty. A two-entry result
//  buffer (output register plus skid register) lets one more item in while
//  a result waits. Reset clears the sequencer to idle with all coils off and
//  restores the register defaults. No clearing pass is needed after reset.
//
module stepper_phase_sequencer #(
	parameter int unsigned ANGLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  sps_pkg::in_item_t                     in_item,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output sps_pkg::out_item_t                    out_item,

	input  logic                                  cfg_we,
	input  logic [sps_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [sps_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
	import sps_pkg::*;

	// The reported angle keeps at most ANGLE_WIDTH bits of the 16-bit field.
	localparam int unsigned ANGLE_KEEP = (ANGLE_WIDTH > 16) ? 16 : ANGLE_WIDTH;
	localparam logic [15:0] ANGLE_MASK = 16'hFFFF >> (16 - ANGLE_KEEP);

	// Configuration registers.
	logic       direction_ccw_q;
	logic       full_step_mode_q;
	logic [7:0] cycles_per_segment_q;

	// Sequencer state.
	logic [15:0] segment_total_q;
	logic [15:0] segment_index_q;
	logic [7:0]  pass_count_q;
	logic [3:0]  phase_index_q;
	logic        moving_q;
	logic [7:0]  held_pattern_q;

	// Result buffer.
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      skid_valid_q;
	out_item_t skid_item_q;

	logic in_acc;
	logic out_take;

	// Next-state values and the result of the item on the input.
	logic [15:0] segment_total_d;
	logic [15:0] segment_index_d;
	logic [7:0]  pass_count_d;
	logic [3:0]  phase_index_d;
	logic        moving_d;
	logic [7:0]  held_pattern_d;
	out_item_t   result;

	logic [31:0] div_prod;
	logic [15:0] start_segments;
	logic [3:0]  start_phase;
	logic [3:0]  cur_phase;
	logic [3:0]  stride;
	logic        pass_end;
	logic [15:0] angle_cur;

	// The input side only stalls when both result entries are full.
	assign in_ready  = !skid_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_take  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Segment count of a move: degrees / 15 through a reciprocal multiply.
	assign div_prod       = in_item.move_degrees * RECIP_15;
	assign start_segments = {3'b000, div_prod[31:RECIP_15_SHIFT]};

	assign start_phase = direction_ccw_q ? PHASE_LAST : PHASE_FIRST;
	// A phase index outside the table reads as the first entry.
	assign cur_phase   = (phase_index_q <= PHASE_LAST) ? phase_index_q : PHASE_FIRST;
	assign stride      = full_step_mode_q ? 4'd2 : 4'd1;

	// The pass ends when the next step would leave the table.
	always_comb begin
		if (direction_ccw_q) begin
			pass_end = cur_phase < stride;
		end else begin
			pass_end = (cur_phase + stride) > PHASE_LAST;
		end
	end

	// Fifteen times the current segment, written as a shift and subtract.
	assign angle_cur = ({segment_index_q[11:0], 4'b0000} - segment_index_q) & ANGLE_MASK;

	always_comb begin
		segment_total_d     = segment_total_q;
		segment_index_d     = segment_index_q;
		pass_count_d        = pass_count_q;
		phase_index_d       = phase_index_q;
		moving_d            = moving_q;
		held_pattern_d      = held_pattern_q;
		result.coil_pattern = held_pattern_q;
		result.angle_now    = 16'd0;
		result.move_done    = 1'b0;

		if (in_item.cmd == CMD_START) begin
			if (moving_q) begin
				// A start during a move is ignored.
				result.angle_now = angle_cur;
			end else begin
				segment_total_d = start_segments;
				pass_count_d    = 8'd0;
				phase_index_d   = start_phase;
				if (start_segments == 16'd0) begin
					// Less than one segment: the move is over at once.
					segment_index_d  = 16'd0;
					result.move_done = 1'b1;
				end else begin
					// The first segment reads fifteen degrees.
					segment_index_d  = 16'd1;
					moving_d         = 1'b1;
					result.angle_now = 16'd15 & ANGLE_MASK;
				end
			end
		end else if (moving_q) begin
			held_pattern_d      = ~phase_entry(cur_phase);
			result.coil_pattern = ~phase_entry(cur_phase);
			result.angle_now    = angle_cur;
			if (pass_end) begin
				phase_index_d = start_phase;
				if (pass_count_q == cycles_per_segment_q - 8'd1) begin
					pass_count_d = 8'd0;
					if (segment_index_q >= segment_total_q) begin
						moving_d         = 1'b0;
						result.move_done = 1'b1;
					end else begin
						segment_index_d = segment_index_q + 16'd1;
					end
				end else begin
					pass_count_d = pass_count_q + 8'd1;
				end
			end else if (direction_ccw_q) begin
				phase_index_d = cur_phase - stride;
			end else begin
				phase_index_d = cur_phase + stride;
			end
		end
		result.busy_res = moving_d;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_ccw_q      <= 1'b0;
			full_step_mode_q     <= 1'b0;
			cycles_per_segment_q <= CYCLES_PER_SEGMENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIRECTION_CCW:      direction_ccw_q      <= cfg_data[0];
				REG_FULL_STEP_MODE:     full_step_mode_q     <= cfg_data[0];
				REG_CYCLES_PER_SEGMENT: cycles_per_segment_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_total_q <= 16'd0;
			segment_index_q <= 16'd0;
			pass_count_q    <= 8'd0;
			phase_index_q   <= PHASE_FIRST;
			moving_q        <= 1'b0;
			held_pattern_q  <= COILS_OFF;
		end else if (in_acc) begin
			segment_total_q <= segment_total_d;
			segment_index_q <= segment_index_d;
			pass_count_q    <= pass_count_d;
			phase_index_q   <= phase_index_d;
			moving_q        <= moving_d;
			held_pattern_q  <= held_pattern_d;
		end
	end

	// Result buffer control. The skid entry fills only while the output entry
	// is held; it moves forward as soon as the output entry is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			if (skid_valid_q) begin
				skid_valid_q <= in_acc;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= in_acc;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result buffer payload.
	always_ff @(posedge clk) begin
		if (out_take && skid_valid_q) begin
			out_item_q  <= skid_item_q;
			skid_item_q <= result;
		end else if (out_take || !out_valid_q) begin
			out_item_q <= result;
		end else if (in_acc) begin
			skid_item_q <= result;
		end
	end

	// The skid entry is never full while the output entry is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item behind an empty output entry");

	// A move in progress always has a current segment within its total.
	assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (segment_index_q != 16'd0) && (segment_index_q <= segment_total_q))
		else $error("segment index outside the move");

	// The phase index never leaves the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_index_q <= PHASE_LAST)
		else $error("phase index beyond the table");

	// A finished move leaves the sequencer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && result.move_done |=> !moving_q)
		else $error("move reported done but still moving");

	// Without an accepted item, the sequencer state holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(segment_index_q) && $stable(phase_index_q) && $stable(moving_q))
		else $error("sequencer state changed without an item");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper phase sequencer testbench
// Drives start and tick items into the sequencer. A cycle-free model of the
// coil walk tracks the move state and the registers, and predicts each
// result. Results are compared in order, field by field. Directed tests
// cover the corner cases. Random traffic then runs under four idling mixes.
// ---------------------------------------------------------------------------
module tb_top;
	import sps_pkg::*;

	// Coil energizing order. The last step repeats the first, so that a pass
	// in either direction ends on the same coil it started with.
	localparam logic [7:0] COIL_STEPS [0:8] = '{
		8'h01, 8'h03, 8'h02, 8'h06, 8'h04, 8'h0C, 8'h08, 8'h09, 8'h01
	};
	localparam int RANDOM_ITEMS_PER_PHASE = 340;
	localparam int MAX_SEND_GAP           = 30;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;

	// Idling mix, in percent of cycles, for the sender and the receiver.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int fail_count    = 0;

	// Register copies, at their reset values.
	logic       dir_ccw    = 1'b0;
	logic       full_step  = 1'b0;
	logic [7:0] pass_limit = CYCLES_PER_SEGMENT_RESET;

	// Move state, at its reset values: idle with all coils off.
	logic [15:0] seg_total   = '0;
	logic [15:0] seg_now     = '0;
	logic [7:0]  pass_cnt    = '0;
	logic [3:0]  phase_pos   = '0;
	logic        move_active = 1'b0;
	logic [7:0]  held_byte   = COILS_OFF;

	// Results predicted for accepted items, oldest first.
	out_item_t pending_coil_results [$];

	stepper_phase_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Angle of a segment: fifteen degrees each, kept to the 16-bit port.
	function automatic logic [15:0] segment_angle(input logic [15:0] seg);
		logic [31:0] prod;
		prod = 32'(seg) * 32'd15;
		return prod[15:0];
	endfunction

	// Applies one accepted item to the move state and returns its result.
	function automatic out_item_t sequence_coils(input in_item_t it);
		out_item_t  r;
		logic [3:0] pos;
		logic [3:0] restart;
		int         stride;
		int         nxt;
		r.coil_pattern = held_byte;
		r.angle_now    = '0;
		r.move_done    = 1'b0;
		restart = dir_ccw ? PHASE_LAST : PHASE_FIRST;
		if (it.cmd == CMD_START) begin
			if (move_active) begin
				// A start during a move is dropped; only the angle is reported.
				r.angle_now = segment_angle(seg_now);
			end else begin
				seg_total = it.move_degrees / 16'd15;
				pass_cnt  = '0;
				phase_pos = restart;
				if (seg_total == '0) begin
					// Less than one segment: the move is over at once.
					seg_now     = '0;
					r.move_done = 1'b1;
				end else begin
					seg_now     = 16'd1;
					move_active = 1'b1;
					r.angle_now = segment_angle(seg_now);
				end
			end
		end else if (move_active) begin
			pos    = (phase_pos <= PHASE_LAST) ? phase_pos : PHASE_FIRST;
			stride = full_step ? 2 : 1;
			// The port is active low: drive the inverse of the step.
			held_byte      = ~COIL_STEPS[pos];
			r.coil_pattern = held_byte;
			r.angle_now    = segment_angle(seg_now);
			nxt = dir_ccw ? int'(pos) - stride : int'(pos) + stride;
			if (nxt < 0 || nxt > int'(PHASE_LAST)) begin
				// One pass through the table is over. A limit of zero wraps
				// the 8-bit compare and so means 256 passes.
				phase_pos = restart;
				if (pass_cnt == pass_limit - 8'd1) begin
					pass_cnt = '0;
					if (seg_now >= seg_total) begin
						move_active = 1'b0;
						r.move_done = 1'b1;
					end else begin
						seg_now = seg_now + 16'd1;
					end
				end else begin
					pass_cnt = pass_cnt + 8'd1;
				end
			end else begin
				phase_pos = 4'(nxt);
			end
		end
		r.busy_res = move_active;
		return r;
	endfunction

	// Offers one item, holds it until taken, predicts its result and then
	// idles the sender for a random number of cycles. With no gap, valid
	// stays high so that the next item follows at once.
	task automatic send_item(input logic cmd_bit, input logic [15:0] degrees);
		in_item_t it;
		int       gap;
		it.cmd          = cmd_bit;
		it.move_degrees = degrees;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		pending_coil_results.push_back(sequence_coils(it));
		gap = 0;
		while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted result has come back,
	// then gives the result buffer time to settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_coil_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes all three registers on consecutive edges, once the block has
	// gone quiet. A move may still be in progress; new values act at once.
	task automatic set_registers(input logic ccw, input logic full, input logic [7:0] passes);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DIRECTION_CCW;
		cfg_data  <= {7'd0, ccw};
		@(posedge clk);
		dir_ccw    = ccw;
		cfg_index <= REG_FULL_STEP_MODE;
		cfg_data  <= {7'd0, full};
		@(posedge clk);
		full_step  = full;
		cfg_index <= REG_CYCLES_PER_SEGMENT;
		cfg_data  <= passes;
		@(posedge clk);
		pass_limit = passes;
		cfg_we    <= 1'b0;
	endtask

	// Ticks until the predicted move is over.
	task automatic finish_move();
		while (move_active)
			send_item(CMD_TICK, 16'($urandom));
	endtask

	// Idle ticks, starts too short for one segment, and a full move at the
	// reset settings (clockwise, half step, 22 passes) with dropped starts.
	task automatic test_reset_and_short_starts();
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_START, 16'd0);
		send_item(CMD_START, 16'd14);
		send_item(CMD_TICK, 16'hFFFF);
		send_item(CMD_START, 16'd15);
		repeat (3) send_item(CMD_TICK, 16'h0000);
		send_item(CMD_START, 16'hFFFF);
		send_item(CMD_START, 16'h0000);
		finish_move();
		send_item(CMD_TICK, 16'h5A5A);
	endtask

	// Both directions with both strides, two segments each.
	task automatic test_step_modes();
		for (int m = 0; m < 4; m++) begin
			set_registers(m[0], m[1], 8'd1);
			send_item(CMD_START, 16'd30);
			finish_move();
		end
	endtask

	// The smallest pass count over three segments.
	task automatic test_pass_limits();
		set_registers(1'b0, 1'b0, 8'd1);
		send_item(CMD_START, 16'd45);
		finish_move();
	endtask

	// Registers rewritten partway through a move, mid-pass.
	task automatic test_changes_mid_move();
		set_registers(1'b0, 1'b0, 8'd2);
		send_item(CMD_START, 16'd60);
		repeat (5) send_item(CMD_TICK, 16'h0000);
		set_registers(1'b1, 1'b1, 8'd3);
		repeat (7) send_item(CMD_TICK, 16'h0000);
		set_registers(1'b0, 1'b1, 8'd2);
		finish_move();
	endtask

	// Mostly short pass counts so that moves finish often.
	task automatic random_registers();
		int pick;
		logic [7:0] passes;
		pick = $urandom_range(99);
		if (pick < 70)
			passes = 8'($urandom_range(3, 1));
		else if (pick < 98)
			passes = 8'($urandom_range(12, 4));
		else
			passes = 8'd255;
		set_registers(1'($urandom_range(1)), 1'($urandom_range(1)), passes);
	endtask

	// Random traffic under each idling mix. Most items are well-formed
	// moves: a start of up to six segments followed by ticks. Idle ticks,
	// starts during a move and register changes mid-move are mixed in.
	// Only items that change the state count toward the phase length.
	task automatic test_random_traffic();
		int send_mix [4];
		int stall_mix [4];
		int counted;
		send_mix  = '{0, 78, 0, 33};
		stall_mix = '{0, 0, 78, 33};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_mix[ph];
			stall_pct     = stall_mix[ph];
			random_registers();
			counted = 0;
			while (counted < RANDOM_ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 2)
					random_registers();
				if (move_active) begin
					if ($urandom_range(99) < 8) begin
						send_item(CMD_START, 16'($urandom));
					end else begin
						send_item(CMD_TICK, 16'($urandom));
						counted++;
					end
				end else if ($urandom_range(99) < 20) begin
					send_item(CMD_TICK, 16'($urandom));
				end else begin
					send_item(CMD_START, 16'($urandom_range(90)));
					counted++;
				end
			end
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// Result checker and receiver stalls. Each result taken is matched
	// against the oldest prediction; out_ready is redrawn every cycle.
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_coil_results.size() == 0) begin
					$error("result with no item waiting for one");
					fail_count++;
				end else begin
					want = pending_coil_results.pop_front();
					if (out_item.coil_pattern !== want.coil_pattern) begin
						$error("coil_pattern: expected %02h, actual %02h",
							want.coil_pattern, out_item.coil_pattern);
						fail_count++;
					end
					if (out_item.angle_now !== want.angle_now) begin
						$error("angle_now: expected %0d, actual %0d",
							want.angle_now, out_item.angle_now);
						fail_count++;
					end
					if (out_item.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0b, actual %0b",
							want.busy_res, out_item.busy_res);
						fail_count++;
					end
					if (out_item.move_done !== want.move_done) begin
						$error("move_done: expected %0b, actual %0b",
							want.move_done, out_item.move_done);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_DIRECTION_CCW;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_short_starts();
		test_step_modes();
		test_pass_limits();
		test_changes_mid_move();
		test_random_traffic();

		wait_idle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// The slowest correct run stays well under 2 ms.
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/sps_pkg.sv
rtl/stepper_phase_sequencer.sv
tb/tb_top.sv
